>>> hw/rtl/rsp_pkg.sv
// Shared types and constants for the sprite projection pipeline.
package rsp_pkg;

  localparam int AddrW = 5;

  typedef enum logic [2:0] {
    RegScreenWidth  = 3'd0,
    RegScreenHeight = 3'd1,
    RegPlayerX      = 3'd2,
    RegPlayerY      = 3'd3,
    RegDirX         = 3'd4,
    RegDirY         = 3'd5,
    RegPlaneX       = 3'd6,
    RegPlaneY       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [12:0] screen_width;
    logic        [12:0] screen_height;
    logic signed [31:0] player_x;
    logic signed [31:0] player_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] plane_x;
    logic signed [31:0] plane_y;
  } cfg_t;

  // flags riding along the camera-space divider
  typedef struct packed {
    logic det_zero;
    logic ovf_x;
    logic ovf_y;
    logic neg_x;
    logic neg_y;
  } div1_pl_t;

  // depth and flags riding along the screen-space divider
  typedef struct packed {
    logic signed [31:0] depth;
    logic               depth_zero;
    logic               ovf_size;
    logic               ovf_center;
    logic               neg_center;
  } div2_pl_t;

endpackage

>>> hw/rtl/rsp_div.sv
// Pipelined restoring divider: one quotient bit per stage, shared divisor for NL numerators.
module rsp_div #(
  parameter int NL = 2,
  parameter int NW = 64,
  parameter int DW = 48,
  parameter int QW = 32,
  parameter int PW = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [NL-1:0][NW-1:0]  num_i,
  input  logic [DW-1:0]          den_i,
  input  logic [PW-1:0]          pl_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [NL-1:0][QW-1:0]  quo_o,
  output logic [PW-1:0]          pl_o
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  // numerator must be below den << QW; callers flag the other cases
  wire [QW-1:0]                  v_s;
  wire [QW-1:0][NL-1:0][NW-1:0]  rem_s;
  wire [QW-1:0][NL-1:0][QW-1:0]  quo_s;
  wire [QW-1:0][DW-1:0]          den_s;
  wire [QW-1:0][PW-1:0]          pl_s;
  wire [QW:0]                    rdy;

  assign rdy[QW] = ready_i;

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int Bit = QW - 1 - k;

    logic                  v_in;
    logic [NL-1:0][NW-1:0] rem_in;
    logic [NL-1:0][NW-1:0] rem_d;
    logic [NL-1:0][QW-1:0] quo_in;
    logic [NL-1:0][QW-1:0] quo_d;
    logic [DW-1:0]         den_in;
    logic [PW-1:0]         pl_in;
    logic [CW-1:0]         trial;
    logic                  v_q;
    logic [NL-1:0][NW-1:0] rem_q;
    logic [NL-1:0][QW-1:0] quo_q;
    logic [DW-1:0]         den_q;
    logic [PW-1:0]         pl_q;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign pl_in  = pl_i;
    end else begin : g_next
      assign v_in   = v_s[k-1];
      assign rem_in = rem_s[k-1];
      assign quo_in = quo_s[k-1];
      assign den_in = den_s[k-1];
      assign pl_in  = pl_s[k-1];
    end

    assign trial  = CW'(den_in) << Bit;
    assign rdy[k] = !v_q || rdy[k+1];

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int l = 0; l < NL; l++) begin
        if (CW'(rem_in[l]) >= trial) begin
          rem_d[l]      = NW'(CW'(rem_in[l]) - trial);
          quo_d[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[k]) begin
        v_q <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        den_q <= den_in;
        pl_q  <= pl_in;
      end
    end

    assign v_s[k]   = v_q;
    assign rem_s[k] = rem_q;
    assign quo_s[k] = quo_q;
    assign den_s[k] = den_q;
    assign pl_s[k]  = pl_q;
  end

  assign ready_o = rdy[0];
  assign valid_o = v_s[QW-1];
  assign quo_o   = quo_s[QW-1];
  assign pl_o    = pl_s[QW-1];

endmodule

>>> hw/rtl/rsp_front.sv
// Front stages: relative position, camera products, determinant and magnitudes.
module rsp_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rsp_pkg::cfg_t           cfg_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [31:0]      sprite_x_i,
  input  logic signed [31:0]      sprite_y_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [1:0][63:0]        num_o,
  output logic [47:0]             den_o,
  output rsp_pkg::div1_pl_t       pl_o
);

  function automatic logic signed [31:0] sat33(input logic signed [32:0] d);
    if (d[32] != d[31]) begin
      sat33 = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat33 = d[31:0];
    end
  endfunction

  // Q16.16 product truncated toward zero
  function automatic logic signed [47:0] qtr(input logic signed [63:0] p);
    logic signed [63:0] t;
    t   = p + (p[63] ? 64'sd65535 : 64'sd0);
    qtr = t[63:16];
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  logic signed [31:0] rx_q, ry_q;
  logic signed [63:0] pd0_q, pd1_q, px0_q, px1_q, py0_q, py1_q;
  logic signed [48:0] det_q, nx_q, ny_q;
  logic [1:0][63:0]   num_q;
  logic [47:0]        den_q;
  rsp_pkg::div1_pl_t  pl_q;

  logic [48:0] ad_full, ax_full, ay_full;

  assign r4      = !v4_q || ready_i;
  assign r3      = !v3_q || r4;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  assign ad_full = det_q[48] ? 49'(-det_q) : 49'(det_q);
  assign ax_full = nx_q[48] ? 49'(-nx_q) : 49'(nx_q);
  assign ay_full = ny_q[48] ? 49'(-ny_q) : 49'(ny_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      rx_q <= sat33(33'(sprite_x_i) - 33'(cfg_i.player_x));
      ry_q <= sat33(33'(sprite_y_i) - 33'(cfg_i.player_y));
    end
    if (r2) begin
      pd0_q <= 64'(cfg_i.plane_x) * 64'(cfg_i.dir_y);
      pd1_q <= 64'(cfg_i.dir_x) * 64'(cfg_i.plane_y);
      px0_q <= 64'(cfg_i.dir_y) * 64'(rx_q);
      px1_q <= 64'(cfg_i.dir_x) * 64'(ry_q);
      py0_q <= 64'(cfg_i.plane_x) * 64'(ry_q);
      py1_q <= 64'(cfg_i.plane_y) * 64'(rx_q);
    end
    if (r3) begin
      det_q <= 49'(qtr(pd0_q)) - 49'(qtr(pd1_q));
      nx_q  <= 49'(qtr(px0_q)) - 49'(qtr(px1_q));
      ny_q  <= 49'(qtr(py0_q)) - 49'(qtr(py1_q));
    end
    if (r4) begin
      num_q[0]      <= {ax_full[47:0], 16'h0};
      num_q[1]      <= {ay_full[47:0], 16'h0};
      den_q         <= ad_full[47:0];
      // quotient of 2^32 or more saturates anyway
      pl_q.ovf_x    <= 64'(ax_full[47:0]) >= {ad_full[47:0], 16'h0};
      pl_q.ovf_y    <= 64'(ay_full[47:0]) >= {ad_full[47:0], 16'h0};
      pl_q.det_zero <= (det_q == '0);
      pl_q.neg_x    <= nx_q[48] ^ det_q[48];
      pl_q.neg_y    <= ny_q[48] ^ det_q[48];
    end
  end

  assign valid_o = v4_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign pl_o    = pl_q;

endmodule

>>> hw/rtl/rsp_scale.sv
// Middle stages: saturate tX/tY, form the center numerator, set up the pixel divisions.
module rsp_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsp_pkg::cfg_t       cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [1:0][31:0]    quo_i,
  input  rsp_pkg::div1_pl_t   pl_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [1:0][45:0]    num_o,
  output logic [31:0]         den_o,
  output rsp_pkg::div2_pl_t   pl_o
);

  function automatic logic signed [31:0] fix_q(input logic [31:0] q, input logic ovf,
                                               input logic neg, input logic zero);
    logic [32:0] mag;
    logic [32:0] nmag;
    mag  = (ovf || q > 32'h8000_0000) ? 33'h0_8000_0000 : {1'b0, q};
    nmag = -mag;
    if (zero) begin
      fix_q = '0;
    end else if (neg) begin
      fix_q = nmag[31:0];
    end else if (mag[31]) begin
      fix_q = 32'sh7fff_ffff;
    end else begin
      fix_q = mag[31:0];
    end
  endfunction

  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;

  logic signed [31:0] tx_q, ty_q, ty2_q;
  logic signed [45:0] cn_q;
  logic [1:0][45:0]   num_q;
  logic [31:0]        den_q;
  rsp_pkg::div2_pl_t  pl_q;

  logic signed [32:0] tsum;
  logic [31:0]        aty;
  logic [45:0]        acn;

  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  assign tsum = 33'(tx_q) + 33'(ty_q);
  assign aty  = ty2_q[31] ? 32'(-ty2_q) : 32'(ty2_q);
  assign acn  = cn_q[45] ? 46'(-cn_q) : 46'(cn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      tx_q <= fix_q(quo_i[0], pl_i.ovf_x, pl_i.neg_x, pl_i.det_zero);
      ty_q <= fix_q(quo_i[1], pl_i.ovf_y, pl_i.neg_y, pl_i.det_zero);
    end
    if (r2) begin
      cn_q  <= 46'($signed({1'b0, cfg_i.screen_width[12:1]})) * 46'(tsum);
      ty2_q <= ty_q;
    end
    if (r3) begin
      num_q[0]        <= 46'({cfg_i.screen_height, 16'h0});
      num_q[1]        <= acn;
      den_q           <= aty;
      pl_q.depth      <= ty2_q;
      pl_q.depth_zero <= (ty2_q == '0);
      pl_q.ovf_size   <= 32'(cfg_i.screen_height) >= aty;
      pl_q.ovf_center <= 48'(acn) >= {aty, 16'h0};
      pl_q.neg_center <= cn_q[45] ^ ty2_q[31];
    end
  end

  assign valid_o = v3_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign pl_o    = pl_q;

endmodule

>>> hw/rtl/rsp_bound.sv
// Last stage: size and center saturation, clamped bounds, output register.
module rsp_bound (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsp_pkg::cfg_t       cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [1:0][15:0]    quo_i,
  input  rsp_pkg::div2_pl_t   pl_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [127:0]        data_o
);

  logic         v_q;
  logic [127:0] data_q;

  logic [15:0]        size;
  logic [16:0]        cmag;
  logic [16:0]        ncmag;
  logic [15:0]        center;
  logic signed [18:0] hh, hw, h, w, half, ctr, r0, r1, c0, c1;

  assign ready_o = !v_q || ready_i;

  always_comb begin
    hw    = 19'({cfg_i.screen_width[12:1]});
    hh    = 19'({cfg_i.screen_height[12:1]});
    w     = 19'(cfg_i.screen_width);
    h     = 19'(cfg_i.screen_height);
    size  = (pl_i.depth_zero || pl_i.ovf_size) ? 16'hffff : quo_i[0];
    cmag  = pl_i.ovf_center ? 17'h1_0000 : {1'b0, quo_i[1]};
    ncmag = -cmag;
    if (pl_i.depth_zero) begin
      center = hw[15:0];
    end else if (pl_i.neg_center) begin
      center = (cmag > 17'd32768) ? 16'h8000 : ncmag[15:0];
    end else begin
      center = (cmag > 17'd32767) ? 16'h7fff : cmag[15:0];
    end
    half = 19'(size[15:1]);
    ctr  = 19'($signed(center));
    r0   = hh - half;
    r1   = hh + half;
    c0   = ctr - half;
    c1   = ctr + half;
    if (r0 < 0) r0 = '0;
    if (r1 >= h) r1 = h - 19'sd1;
    if (c0 < 0) c0 = '0;
    if (c1 >= w) c1 = w - 19'sd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= {c1[15:0], c0[15:0], r1[15:0], r0[15:0], size, center, pl_i.depth};
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/raycast_sprite_projection.sv
// Top level: sprite billboard projection pipeline with its register port.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-------------------------------------------
//  s_axis    | in  | tvalid/tready          | tdata: sprite_x, sprite_y (64b)
//  m_axis    | out | tvalid/tready          | tdata: depth, center, size, rows, cols (128b)
//  apb       | in  | psel/penable/pwrite    | 8 registers at 4*i, pready always high
//
// One sprite per cycle while the output is not stalled; a request passes through 4 front
// stages, a 32-stage divider for tX/tY, 3 scaling stages, a 16-stage divider for size
// and center, and one output stage. The dividers' one bit per stage sets the depth.
// Reset empties the pipeline and loads the default camera and screen.
// A stalled output holds its stage; upstream stages keep filling until full.
module raycast_sprite_projection (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [63:0]               s_axis_tdata_i,   // sprite_x, sprite_y
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // depth, center_column, sprite_size, first_row, last_row, first_column, last_column
  output logic [127:0]              m_axis_tdata_o,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [rsp_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]               pwdata_i,
  output logic [31:0]               prdata_o,
  output logic                      pready_o
);

  rsp_pkg::cfg_t     cfg_q;
  rsp_pkg::cfg_reg_e reg_sel;

  logic              f_valid, f_ready;
  logic [1:0][63:0]  f_num;
  logic [47:0]       f_den;
  rsp_pkg::div1_pl_t f_pl;

  logic              d1_valid, d1_ready;
  logic [1:0][31:0]  d1_quo;
  logic [4:0]        d1_pl;

  logic              s_valid, s_ready;
  logic [1:0][45:0]  s_num;
  logic [31:0]       s_den;
  rsp_pkg::div2_pl_t s_pl;

  logic              d2_valid, d2_ready;
  logic [1:0][15:0]  d2_quo;
  logic [$bits(rsp_pkg::div2_pl_t)-1:0] d2_pl;

  assign pready_o = 1'b1;
  assign reg_sel  = rsp_pkg::cfg_reg_e'(paddr_i[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= 13'd640;
      cfg_q.screen_height <= 13'd480;
      cfg_q.player_x      <= '0;
      cfg_q.player_y      <= '0;
      cfg_q.dir_x         <= -32'sd65536;
      cfg_q.dir_y         <= '0;
      cfg_q.plane_x       <= '0;
      cfg_q.plane_y       <= 32'sd43254;
    end else if (psel_i && penable_i && pwrite_i && pready_o) begin
      case (reg_sel)
        rsp_pkg::RegScreenWidth:  cfg_q.screen_width  <= pwdata_i[12:0];
        rsp_pkg::RegScreenHeight: cfg_q.screen_height <= pwdata_i[12:0];
        rsp_pkg::RegPlayerX:      cfg_q.player_x      <= pwdata_i;
        rsp_pkg::RegPlayerY:      cfg_q.player_y      <= pwdata_i;
        rsp_pkg::RegDirX:         cfg_q.dir_x         <= pwdata_i;
        rsp_pkg::RegDirY:         cfg_q.dir_y         <= pwdata_i;
        rsp_pkg::RegPlaneX:       cfg_q.plane_x       <= pwdata_i;
        rsp_pkg::RegPlaneY:       cfg_q.plane_y       <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rsp_pkg::RegScreenWidth:  prdata_o = 32'(cfg_q.screen_width);
      rsp_pkg::RegScreenHeight: prdata_o = 32'(cfg_q.screen_height);
      rsp_pkg::RegPlayerX:      prdata_o = cfg_q.player_x;
      rsp_pkg::RegPlayerY:      prdata_o = cfg_q.player_y;
      rsp_pkg::RegDirX:         prdata_o = cfg_q.dir_x;
      rsp_pkg::RegDirY:         prdata_o = cfg_q.dir_y;
      rsp_pkg::RegPlaneX:       prdata_o = cfg_q.plane_x;
      rsp_pkg::RegPlaneY:       prdata_o = cfg_q.plane_y;
      default:                  prdata_o = '0;
    endcase
  end

  rsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .sprite_x_i ($signed(s_axis_tdata_i[31:0])),
    .sprite_y_i ($signed(s_axis_tdata_i[63:32])),
    .valid_o    (f_valid),
    .ready_i    (f_ready),
    .num_o      (f_num),
    .den_o      (f_den),
    .pl_o       (f_pl)
  );

  rsp_div #(.NL(2), .NW(64), .DW(48), .QW(32), .PW(5)) u_div_cam (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .num_i   (f_num),
    .den_i   (f_den),
    .pl_i    (f_pl),
    .valid_o (d1_valid),
    .ready_i (d1_ready),
    .quo_o   (d1_quo),
    .pl_o    (d1_pl)
  );

  rsp_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (d1_valid),
    .ready_o (d1_ready),
    .quo_i   (d1_quo),
    .pl_i    (rsp_pkg::div1_pl_t'(d1_pl)),
    .valid_o (s_valid),
    .ready_i (s_ready),
    .num_o   (s_num),
    .den_o   (s_den),
    .pl_o    (s_pl)
  );

  rsp_div #(.NL(2), .NW(46), .DW(32), .QW(16), .PW($bits(rsp_pkg::div2_pl_t))) u_div_pix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .ready_o (s_ready),
    .num_i   (s_num),
    .den_i   (s_den),
    .pl_i    (s_pl),
    .valid_o (d2_valid),
    .ready_i (d2_ready),
    .quo_o   (d2_quo),
    .pl_o    (d2_pl)
  );

  rsp_bound u_bound (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (d2_valid),
    .ready_o (d2_ready),
    .quo_i   (d2_quo),
    .pl_i    (rsp_pkg::div2_pl_t'(d2_pl)),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

  // back-pressure only originates at a waiting result
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a waiting result");

  a_low_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[79] && !m_axis_tdata_o[111])
    else $error("first row or column below zero");

  a_zero_depth_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[31:0] == '0 |-> m_axis_tdata_o[63:48] == 16'hffff)
    else $error("zero depth without saturated size");

  a_zero_depth_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[31:0] == '0
      |-> m_axis_tdata_o[47:32] == {4'b0, cfg_q.screen_width[12:1]})
    else $error("zero depth center not at mid screen");

endmodule

>>> test/rsp_checker.sv
// Checker: mirrors the register port, predicts each sprite projection, compares results.
module rsp_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [63:0]  s_data_i,    // sprite_x, sprite_y
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [127:0] m_data_i,    // depth, center, size, first/last row, first/last col
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [rsp_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]  pwdata_i,
  input  logic         pready_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] depth;
    logic signed [15:0] center_column;
    logic        [15:0] sprite_size;
    logic signed [15:0] first_row;
    logic signed [15:0] last_row;
    logic signed [15:0] first_column;
    logic signed [15:0] last_column;
  } projection_t;

  rsp_pkg::cfg_t cam;
  projection_t   projections_q[$];

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) / 65536;
  endfunction

  // exact (num << 16) / den, toward zero, saturated to int32
  function automatic longint fx_div(longint num, longint den);
    longint unsigned an, ad, q;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q  = (an << 16) / ad;
    if (q > 64'd2147483648) q = 64'd2147483648;
    if ((num < 0) != (den < 0)) return -longint'(q);
    return q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic projection_t project_sprite(logic signed [31:0] sx,
                                                 logic signed [31:0] sy);
    projection_t p;
    longint rx, ry, det, nx, ny, tx, ty, w, h, hw, hh, cen, sz, half;
    longint r0, r1, c0, c1;
    longint unsigned aty, q;
    rx  = clamp(longint'(sx) - longint'(cam.player_x), -64'sd2147483648, 64'sd2147483647);
    ry  = clamp(longint'(sy) - longint'(cam.player_y), -64'sd2147483648, 64'sd2147483647);
    det = fx_mul(cam.plane_x, cam.dir_y) - fx_mul(cam.dir_x, cam.plane_y);
    nx  = fx_mul(cam.dir_y, rx) - fx_mul(cam.dir_x, ry);
    ny  = fx_mul(cam.plane_x, ry) - fx_mul(cam.plane_y, rx);
    tx  = 0;
    ty  = 0;
    w   = longint'({19'd0, cam.screen_width});
    h   = longint'({19'd0, cam.screen_height});
    hw  = w / 2;
    hh  = h / 2;
    if (det != 0) begin
      tx = fx_div(nx, det);
      ty = fx_div(ny, det);
    end
    if (ty == 0) begin
      sz  = 65535;
      cen = hw;
    end else begin
      aty = ty < 0 ? -ty : ty;
      q   = (longint'(h) << 16) / aty;
      sz  = q > 65535 ? 65535 : longint'(q);
      cen = (hw * (ty + tx)) / ty;
    end
    cen  = clamp(cen, -32768, 32767);
    half = sz / 2;
    r0 = hh - half;
    if (r0 < 0) r0 = 0;
    r1 = hh + half;
    if (r1 >= h) r1 = h - 1;
    c0 = cen - half;
    if (c0 < 0) c0 = 0;
    c1 = cen + half;
    if (c1 >= w) c1 = w - 1;
    p.depth         = ty[31:0];
    p.center_column = cen[15:0];
    p.sprite_size   = sz[15:0];
    p.first_row     = 16'(clamp(r0, -32768, 32767));
    p.last_row      = 16'(clamp(r1, -32768, 32767));
    p.first_column  = 16'(clamp(c0, -32768, 32767));
    p.last_column   = 16'(clamp(c1, -32768, 32767));
    return p;
  endfunction

  function automatic int field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      return 0;
    end
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    projection_t e, a;
    int ok;
    if (!rst_ni) begin
      cam.screen_width  <= 13'd640;
      cam.screen_height <= 13'd480;
      cam.player_x      <= 0;
      cam.player_y      <= 0;
      cam.dir_x         <= -32'sd65536;
      cam.dir_y         <= 0;
      cam.plane_x       <= 0;
      cam.plane_y       <= 32'sd43254;
      projections_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (s_valid_i && s_ready_i) projections_q.push_back(project_sprite(s_data_i[31:0],
                                                                         s_data_i[63:32]));
      if (m_valid_i && m_ready_i) begin
        a.depth         = m_data_i[31:0];
        a.center_column = m_data_i[47:32];
        a.sprite_size   = m_data_i[63:48];
        a.first_row     = m_data_i[79:64];
        a.last_row      = m_data_i[95:80];
        a.first_column  = m_data_i[111:96];
        a.last_column   = m_data_i[127:112];
        if (projections_q.size() == 0) begin
          $error("result with no request outstanding: %0h", m_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e  = projections_q.pop_front();
          ok = field_ok("depth", e.depth, a.depth)
             & field_ok("center_column", 32'(e.center_column), 32'(a.center_column))
             & field_ok("sprite_size", 32'(e.sprite_size), 32'(a.sprite_size))
             & field_ok("first_row", 32'(e.first_row), 32'(a.first_row))
             & field_ok("last_row", 32'(e.last_row), 32'(a.last_row))
             & field_ok("first_column", 32'(e.first_column), 32'(a.first_column))
             & field_ok("last_column", 32'(e.last_column), 32'(a.last_column));
          if (!ok) fail_count_o <= fail_count_o + 1;
        end
      end
      pending_o <= projections_q.size();
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (rsp_pkg::cfg_reg_e'(paddr_i[4:2]))
          rsp_pkg::RegScreenWidth:  cam.screen_width  <= pwdata_i[12:0];
          rsp_pkg::RegScreenHeight: cam.screen_height <= pwdata_i[12:0];
          rsp_pkg::RegPlayerX:      cam.player_x      <= pwdata_i;
          rsp_pkg::RegPlayerY:      cam.player_y      <= pwdata_i;
          rsp_pkg::RegDirX:         cam.dir_x         <= pwdata_i;
          rsp_pkg::RegDirY:         cam.dir_y         <= pwdata_i;
          rsp_pkg::RegPlaneX:       cam.plane_x       <= pwdata_i;
          rsp_pkg::RegPlaneY:       cam.plane_y       <= pwdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> test/tb_top.sv
// Testbench top: clock, reset, register setup, sprite stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [63:0]  s_data = '0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [127:0] m_data;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rsp_pkg::AddrW-1:0] paddr = '0;
  logic [31:0]  pwdata = '0, prdata;
  logic         pready;
  int           fail_count, pending;
  bit           calm = 1'b0;      // no idling on either side
  bit           hold_go = 1'b0;   // arms the long output stall

  raycast_sprite_projection dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  rsp_checker chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  // output side: random stalls, one long hold-off once armed
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      m_ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  task automatic write_reg(rsp_pkg::cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rsp_pkg::AddrW'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_sprite(logic [31:0] sx, logic [31:0] sy);
    bit rdy;
    while (!calm && $urandom_range(99) < 34) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {sy, sx};
    do begin
      @(negedge clk_i);
      rdy = s_ready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // called right at the edge that took the last request
  task automatic drain;
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_camera(logic [12:0] w, logic [12:0] h, logic [31:0] px, logic [31:0] py,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] lx,
                            logic [31:0] ly);
    write_reg(rsp_pkg::RegScreenWidth, 32'(w));
    write_reg(rsp_pkg::RegScreenHeight, 32'(h));
    write_reg(rsp_pkg::RegPlayerX, px);
    write_reg(rsp_pkg::RegPlayerY, py);
    write_reg(rsp_pkg::RegDirX, dx);
    write_reg(rsp_pkg::RegDirY, dy);
    write_reg(rsp_pkg::RegPlaneX, lx);
    write_reg(rsp_pkg::RegPlaneY, ly);
  endtask

  function automatic logic [31:0] near_val(logic [31:0] base, int unsigned span);
    return base + $urandom_range(2 * span) - span;
  endfunction

  function automatic logic [31:0] cam_comp();
    logic [31:0] v;
    v = $urandom_range(32'h3_0000);
    return $urandom_range(1) ? v : -v;
  endfunction

  initial begin
    logic [31:0] px, py;
    int unsigned sel, span;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // default camera: zero depth, in front, behind, extremes, very near
    send_sprite(32'h0, 32'h0);
    send_sprite(-32'sd327680, 32'h0);
    send_sprite(32'sd327680, 32'sd196608);
    send_sprite(32'h7fff_ffff, 32'h7fff_ffff);
    send_sprite(32'h8000_0000, 32'h8000_0000);
    send_sprite(32'h8000_0000, 32'h7fff_ffff);
    send_sprite(-32'sd1, 32'sd1);
    send_sprite(-32'sd65536, 32'sd6553600);
    drain();
    // relative position saturates
    set_camera(13'd1, 13'd1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
               32'h8000_0000, 32'h7fff_ffff);
    send_sprite(32'h7fff_ffff, 32'h8000_0000);
    send_sprite(32'h8000_0000, 32'h7fff_ffff);
    send_sprite(32'h0, 32'h0);
    drain();
    // zero determinant
    set_camera(13'd4096, 13'd4096, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_sprite(32'h1234_5678, 32'h8765_4321);
    send_sprite(32'h0, 32'h0);
    drain();
    // out-of-range screen sizes
    set_camera(13'd0, 13'd8191, 32'h0, 32'h0, -32'sd65536, 32'h0, 32'h0, 32'sd43254);
    send_sprite(-32'sd131072, 32'sd65536);
    send_sprite(-32'sd1048576, 32'h0);
    drain();
    write_reg(rsp_pkg::RegScreenWidth, 32'd8191);
    write_reg(rsp_pkg::RegScreenHeight, 32'd0);
    send_sprite(-32'sd131072, -32'sd65536);
    send_sprite(32'sd2, 32'sd2);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 4);
      px = $urandom_range(32'h80_0000) - 32'h40_0000;
      py = $urandom_range(32'h80_0000) - 32'h40_0000;
      case (ph)
        0: set_camera(13'd1, 13'd4096, px, py, cam_comp(), cam_comp(), cam_comp(),
                      cam_comp());
        1: set_camera(13'd4096, 13'd1, px, py, cam_comp(), cam_comp(), cam_comp(),
                      cam_comp());
        7, 8: set_camera(13'($urandom), 13'($urandom), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        default: set_camera(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)),
                            px, py, cam_comp(), cam_comp(), cam_comp(), cam_comp());
      endcase
      if (ph == 1) hold_go = 1'b1;
      for (int k = 0; k < 133; k++) begin
        sel  = $urandom_range(99);
        span = sel < 10 ? 32'h1000 : 32'h40_0000;
        if (sel < 85) send_sprite(near_val(px, span), near_val(py, span));
        else send_sprite($urandom, $urandom);
      end
      drain();
    end
    calm = 1'b0;

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
